>>> rtl/majority_element_vote_unit_assert.svh
// Assertion macros for the majority vote unit.
`ifndef MAJORITY_ELEMENT_VOTE_UNIT_ASSERT_SVH
`define MAJORITY_ELEMENT_VOTE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MEV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MEV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mev_pkg.sv
// Shared types and constants for the majority vote unit.
package mev_pkg;

   localparam int DATA_WIDTH        = 32;
   localparam int MAX_ITEMS_DEFAULT = 1024;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_item;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] majority;
      logic                         found;
      logic                         overflowed;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // input word accepted
      logic scan_read;  // issue one store read
      logic finish;     // publish result, clear list state
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic issue_done;  // every stored word has been read
      logic rd_pending;  // a read is still in the compare stage
      logic out_free;    // output register can take a result
   } status_type;

endpackage

>>> rtl/majority_element_vote_unit.sv
// Top level of the majority vote unit: sequencer plus datapath.
//
// Majority vote unit. Takes a list of signed 32-bit words, one word per cycle,
// with last_item set on the final word, and returns one result word per list:
// the majority value with found=1 if it occurs in more than half the stored
// words, else majority=0 with found=0. Up to MAX_ITEMS words are stored; words
// beyond that are dropped (not voted, not counted) and overflowed is set in the
// result. Each list passes through load (req_stall low), then a rescan of the
// on-chip store at one read per cycle through its single read port, then a
// publish step. req_stall is high during the rescan and publish. The result
// sits in an output register, so loading of the next list starts while the
// previous result waits to be taken; only publishing the next result waits on
// a free output register. The store needs no clearing after reset: only words
// written for the current list are read back.
module majority_element_vote_unit
   import mev_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "majority_element_vote_unit_assert.svh"

   cmd_type    cmd;
   status_type status;

   // Sequencer: load words, then walk the store, then hand off the result
   mev_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_item),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Store, vote counter, match counter and output register
   mev_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_data.value),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A word is only loaded when the handshake really completes
   `MEV_ASSERT_NOW(a_load_on_accept, cmd.load, req_valid && !req_stall, "load without accept")
   // Never overwrite a result still waiting downstream
   `MEV_ASSERT_NOW(a_finish_free, cmd.finish, status.out_free, "result overwritten")
   // A published result shows up on the next cycle
   `MEV_ASSERT_NEXT(a_finish_valid, cmd.finish, rsp_valid, "result not presented")
   // No majority means a zero value
   `MEV_ASSERT_NOW(a_zero_if_none, rsp_valid && !rsp_data.found, rsp_data.majority == '0,
                   "nonzero majority without found")

endmodule

>>> rtl/mev_ctrl.sv
// Sequencer for the majority vote unit: load, scan, publish.
module mev_ctrl
   import mev_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_stall     = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!status.issue_done) begin
               cmd.scan_read = 1'b1;
            end else if (!status.rd_pending) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/mev_datapath.sv
// Datapath for the majority vote unit: store, vote, scan count, output register.
module mev_datapath
   import mev_pkg::*;
#(
   parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);

   logic [DATA_WIDTH-1:0] mem [MAX_ITEMS];

   logic [DATA_WIDTH-1:0] cand_ff,  cand_in;
   logic [CW-1:0]         vote_ff,  vote_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         match_ff, match_in;
   logic [CW-1:0]         idx_ff,   idx_in;
   logic                  drop_ff,  drop_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff,   rsp_in;
   logic                  full;
   logic                  found;

   assign full  = (count_ff == CW'(MAX_ITEMS));
   assign found = (match_ff > (count_ff >> 1));

   assign status.issue_done = (idx_ff == count_ff);
   assign status.rd_pending = rd_valid_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // Store write and scan read
   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[count_ff[AW-1:0]] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_read) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      cand_in  = cand_ff;
      vote_in  = vote_ff;
      count_in = count_ff;
      match_in = match_ff;
      idx_in   = idx_ff;
      drop_in  = drop_ff;

      if (cmd.load) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            if (vote_ff == '0) begin
               cand_in = req_value;
               vote_in = CW'(1);
            end else if (req_value == cand_ff) begin
               vote_in = vote_ff + 1'b1;
            end else begin
               vote_in = vote_ff - 1'b1;
            end
         end
      end

      if (cmd.scan_read) begin
         idx_in = idx_ff + 1'b1;
      end
      if (rd_valid_ff && (rd_data_ff == cand_ff)) begin
         match_in = match_ff + 1'b1;
      end

      if (cmd.finish) begin
         cand_in  = '0;
         vote_in  = '0;
         count_in = '0;
         match_in = '0;
         idx_in   = '0;
         drop_in  = 1'b0;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.majority     = found ? cand_ff : '0;
         rsp_in.found        = found;
         rsp_in.overflowed   = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff      <= '0;
         vote_ff      <= '0;
         count_ff     <= '0;
         match_ff     <= '0;
         idx_ff       <= '0;
         drop_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cand_ff      <= cand_in;
         vote_ff      <= vote_in;
         count_ff     <= count_in;
         match_ff     <= match_in;
         idx_ff       <= idx_in;
         drop_ff      <= drop_in;
         rd_valid_ff  <= cmd.scan_read;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
